// File: design/atb_pkg.sv
// Shared types and constants of the address text to bytes parser.
`timescale 1ns / 1ps

package atb_pkg;

  // Status codes carried by the summary result of a string.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEC_LONG = 2'd1;
  localparam logic [1:0] ST_HEX_ODD  = 2'd2;
  localparam logic [1:0] ST_UNDEF    = 2'd3;

  // Width of the packed output data word: byte, status and count, padded to bytes.
  localparam int OUT_DATA_W = 32;

  // Work for the back end that one accepted character leaves behind.
  typedef struct packed {
    logic [1:0]  n_data;      // number of data bytes, zero to two
    logic        fin;         // a summary result follows the data bytes
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [1:0]  status;      // status of the summary
    logic [15:0] base_count;  // bytes emitted for the string before this request
  } entry_t;

  // One request moving through the queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } req_t;

endpackage

// File: design/atb_front.sv
// Front end: accepts characters, tracks the token state and forms output requests.
`timescale 1ns / 1ps

module atb_front
  import atb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_eos,
  input  logic       queue_full,
  output req_t       push
);

  typedef enum logic [2:0] {
    MODE_TOP,
    MODE_DEC,
    MODE_WORD,
    MODE_HEX,
    MODE_ALPHA,
    MODE_DONE
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [2:0] DC_SAT   = 3'd4;
  localparam logic [2:0] DC_MAX   = 3'd3;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h46);
  endfunction

  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h66);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (is_dec(c)) begin
      v = c - 8'h30;
    end else if (is_lower_hex(c)) begin
      v = c - 8'h57;
    end else if (is_upper_hex(c)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  mode_t       mode, mode_next;
  logic [15:0] accumulator, accumulator_next;
  logic [2:0]  digit_count, digit_count_next;
  logic        nibble_phase, nibble_phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [15:0] emitted_count, emitted_count_next;

  logic        accept;
  logic        char_dec, char_hex;
  logic [3:0]  nib;
  logic [15:0] acc_times_ten;
  logic        cont;
  logic [1:0]  nd;
  logic [7:0]  d0, d1;
  logic        fin;
  logic [1:0]  st;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign char_dec = is_dec(in_char);
  assign char_hex = char_dec || is_upper_hex(in_char) || is_lower_hex(in_char);
  assign nib      = nibble(in_char);

  // Accumulator times ten plus the new digit, kept to 16 bits.
  assign acc_times_ten = {accumulator[12:0], 3'b000} + {accumulator[14:0], 1'b0}
                       + {12'h000, nib};

  // A character that extends the open token.
  assign cont = ((mode == MODE_DEC) && char_dec) || ((mode == MODE_WORD) && char_dec)
             || ((mode == MODE_HEX) && char_hex)
             || ((mode == MODE_ALPHA) && is_alpha(in_char));

  // Token update, byte emission and end of string handling for one character.
  always_comb begin
    mode_next          = mode;
    accumulator_next   = accumulator;
    digit_count_next   = digit_count;
    nibble_phase_next  = nibble_phase;
    high_nibble_next   = high_nibble;
    emitted_count_next = emitted_count;
    nd                 = 2'd0;
    d0                 = 8'h00;
    d1                 = 8'h00;
    fin                = 1'b0;
    st                 = ST_OK;

    if (mode == MODE_DONE) begin
      // Everything is ignored until the end of string flag restarts the parser.
      if (in_eos) begin
        mode_next          = MODE_TOP;
        accumulator_next   = 16'h0000;
        digit_count_next   = 3'd0;
        nibble_phase_next  = 1'b0;
        high_nibble_next   = 4'h0;
        emitted_count_next = 16'h0000;
      end
    end else begin
      if (cont) begin
        unique case (mode)
          MODE_DEC: begin
            accumulator_next = acc_times_ten;
            if (digit_count < DC_SAT) begin
              digit_count_next = digit_count + 3'd1;
            end
          end
          MODE_WORD: begin
            accumulator_next = acc_times_ten;
          end
          MODE_HEX: begin
            if (nibble_phase) begin
              nd                = 2'd1;
              d0                = {high_nibble, nib};
              nibble_phase_next = 1'b0;
            end else begin
              high_nibble_next  = nib;
              nibble_phase_next = 1'b1;
            end
          end
          default: begin
            nd = 2'd1;
            d0 = in_char;
          end
        endcase

        // The last character closes the token it extended.
        if (in_eos) begin
          fin = 1'b1;
          unique case (mode)
            MODE_DEC: begin
              nd = 2'd1;
              d0 = acc_times_ten[7:0];
              if (digit_count_next > DC_MAX) begin
                st = ST_DEC_LONG;
              end
            end
            MODE_WORD: begin
              nd = 2'd2;
              d0 = acc_times_ten[15:8];
              d1 = acc_times_ten[7:0];
            end
            MODE_HEX: begin
              if (nibble_phase_next) begin
                nd = 2'd1;
                d0 = {nib, 4'h0};
                st = ST_HEX_ODD;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        // Close the open token, then take the character at top level.
        unique case (mode)
          MODE_DEC: begin
            nd = 2'd1;
            d0 = accumulator[7:0];
            if (digit_count > DC_MAX) begin
              st  = ST_DEC_LONG;
              fin = 1'b1;
            end
          end
          MODE_WORD: begin
            nd = 2'd2;
            d0 = accumulator[15:8];
            d1 = accumulator[7:0];
          end
          MODE_HEX: begin
            if (nibble_phase) begin
              nd  = 2'd1;
              d0  = {high_nibble, 4'h0};
              st  = ST_HEX_ODD;
              fin = 1'b1;
            end
          end
          default: begin
          end
        endcase
        mode_next         = MODE_TOP;
        accumulator_next  = 16'h0000;
        digit_count_next  = 3'd0;
        nibble_phase_next = 1'b0;
        high_nibble_next  = 4'h0;

        if (!fin) begin
          unique case (in_char)
            CH_CR, CH_LF, CH_NUL: begin
              fin = 1'b1;
            end
            CH_DOT: begin
              mode_next = in_eos ? MODE_TOP : MODE_DEC;
              fin       = in_eos;
            end
            CH_COLON: begin
              mode_next = in_eos ? MODE_TOP : MODE_WORD;
              fin       = in_eos;
            end
            CH_HASH: begin
              mode_next = in_eos ? MODE_TOP : MODE_HEX;
              fin       = in_eos;
            end
            CH_AT: begin
              mode_next = in_eos ? MODE_TOP : MODE_ALPHA;
              fin       = in_eos;
            end
            CH_UNDER: begin
              fin = in_eos;
            end
            default: begin
              fin = 1'b1;
              st  = ST_UNDEF;
            end
          endcase
        end
      end

      // After the summary, wait for the end of string or restart at once.
      if (fin && in_eos) begin
        mode_next          = MODE_TOP;
        accumulator_next   = 16'h0000;
        digit_count_next   = 3'd0;
        nibble_phase_next  = 1'b0;
        high_nibble_next   = 4'h0;
        emitted_count_next = 16'h0000;
      end else begin
        if (fin) begin
          mode_next = MODE_DONE;
        end
        emitted_count_next = emitted_count + {14'h0000, nd};
      end
    end
  end

  // Request for the back end; characters that give no result leave none.
  always_comb begin
    push.valid            = accept && ((nd != 2'd0) || fin);
    push.entry.n_data     = nd;
    push.entry.fin        = fin;
    push.entry.byte0      = d0;
    push.entry.byte1      = d1;
    push.entry.status     = fin ? st : ST_OK;
    push.entry.base_count = emitted_count;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_TOP;
      accumulator   <= 16'h0000;
      digit_count   <= 3'd0;
      nibble_phase  <= 1'b0;
      high_nibble   <= 4'h0;
      emitted_count <= 16'h0000;
    end else if (accept) begin
      mode          <= mode_next;
      accumulator   <= accumulator_next;
      digit_count   <= digit_count_next;
      nibble_phase  <= nibble_phase_next;
      high_nibble   <= high_nibble_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

// File: design/atb_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module atb_queue
  import atb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  req_t push,
  output logic full,
  output req_t head,
  input  logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: design/atb_back.sv
// Back end: per request, one result a cycle into the output register unless stalled.
`timescale 1ns / 1ps

module atb_back
  import atb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_kind,
  output logic                  out_last
);

  logic [1:0]  idx;
  logic [1:0]  total;
  logic [1:0]  idx_inc;
  logic        is_sum;
  logic        is_last;
  logic        load;
  logic [7:0]  cur_byte;
  logic [1:0]  cur_status;
  logic [15:0] cur_count;

  // Result selected by the position within the head request.
  assign total      = head.entry.n_data + {1'b0, head.entry.fin};
  assign idx_inc    = idx + 2'd1;
  assign is_sum     = head.entry.fin && (idx == head.entry.n_data);
  assign is_last    = (idx_inc == total);
  assign cur_byte   = is_sum ? 8'h00 : ((idx == 2'd0) ? head.entry.byte0 : head.entry.byte1);
  assign cur_status = is_sum ? head.entry.status : ST_OK;
  assign cur_count  = head.entry.base_count + {14'h0000, idx} + {15'h0000, !is_sum};

  assign load = head.valid && (!out_valid || out_ready);
  assign pop  = load && is_last;

  // Output register and position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx_inc;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {6'b000000, cur_count, cur_status, cur_byte};
      out_kind <= is_sum;
      out_last <= is_last;
    end
  end

endmodule

// File: design/address_text_to_bytes_parser.sv
// Top level of the address text to bytes parser.
`timescale 1ns / 1ps

// Takes one character of an address string per request on the slave side and
// gives the bytes it encodes, then one summary per string with its status and
// byte count, on the master side. A character is accepted in every cycle while
// the request queue between front and back end has room; the front end settles
// the token state in the cycle of acceptance. The back end gives one result per
// cycle while the output is not stalled, so a character that causes several
// results (a closing decimal word gives two bytes, possibly with a summary)
// holds the output until all are given, and the queue of QUEUE_DEPTH requests
// absorbs such bursts and output stalls.

module address_text_to_bytes_parser
  import atb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // char_in
  input  logic                  s_tlast,   // end_of_string
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // data_byte [7:0], status [9:8], byte_count [25:10]
  output logic                  m_tuser,   // kind
  output logic                  m_tlast    // run_end
);

  req_t push;
  req_t head;
  logic full;
  logic pop;

  atb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata),
    .in_eos     (s_tlast),
    .queue_full (full),
    .push       (push)
  );

  atb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  atb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

// File: design/atb_port_checker.sv
// Port level checks of the address text to bytes parser, bound to the top level.
`timescale 1ns / 1ps

module atb_port_checker
  import atb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // A stalled result stays offered unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled result changed");

  // A summary is always the last result of its request.
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("summary not marked as last result");

  // Data bytes carry no error status.
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[9:8] == ST_OK))
    else $error("data result with non-zero status");

  // A summary carries a zero data byte and the padding stays clear.
  a_sum_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[31:26] == 6'b000000) && (!m_tuser || (m_tdata[7:0] == 8'h00))))
    else $error("summary byte or padding not zero");

  // After a data byte that does not end its request, the next result counts on.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser && !m_tlast) |=>
      (!m_tvalid || (m_tdata[25:10] == ($past(m_tdata[25:10]) + {15'h0000, !m_tuser}))))
    else $error("byte count did not follow within a request");

endmodule

bind address_text_to_bytes_parser atb_port_checker u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: tb/tb_address_text_to_bytes_parser.sv
// Self-checking testbench of the address text to bytes parser, with its own parser model.
`timescale 1ns / 1ps

module tb_address_text_to_bytes_parser;
  import atb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SKIP  = 8'h5F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    PM_TOP, PM_DEC, PM_WORD, PM_HEX, PM_ALPHA, PM_DONE
  } parse_mode_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        run_end;
  } parse_res_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;   // char_in
  logic                  s_tlast = 1'b0;    // end_of_string
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;           // data_byte [7:0], status [9:8], byte_count [25:10]
  logic                  m_tuser;           // kind
  logic                  m_tlast;           // run_end

  // Model state of the parser.
  parse_mode_t mdl_mode;
  logic [15:0] mdl_acc;
  logic [2:0]  mdl_digits;
  logic        mdl_phase;
  logic [3:0]  mdl_high;
  logic [15:0] mdl_count;

  parse_res_t step_res[$];
  parse_res_t byte_expect_q[$];
  parse_res_t want;

  int   errors = 0;
  int   cycle_count = 0;
  logic no_idle = 1'b0;
  logic holding = 1'b0;
  event hold_go;

  address_text_to_bytes_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Character classes.
  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (is_dec(c)) return 4'(c - CH_ZERO);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
    return 4'h0;
  endfunction

  function automatic void clear_token();
    mdl_acc    = 16'h0000;
    mdl_digits = 3'd0;
    mdl_phase  = 1'b0;
    mdl_high   = 4'h0;
  endfunction

  function automatic void restart_parser();
    mdl_mode  = PM_TOP;
    clear_token();
    mdl_count = 16'h0000;
  endfunction

  // Adds one result of the current request; data bytes advance the count.
  function automatic void emit(input logic kind, input logic [7:0] b, input logic [1:0] st);
    parse_res_t r;
    if (!kind) mdl_count = mdl_count + 16'd1;
    r.kind       = kind;
    r.data_byte  = b;
    r.status     = st;
    r.byte_count = mdl_count;
    r.run_end    = 1'b0;
    step_res.push_back(r);
  endfunction

  // Closes the open token and gives the error status it causes.
  function automatic logic [1:0] close_token();
    logic [1:0] st;
    st = ST_OK;
    case (mdl_mode)
      PM_DEC: begin
        emit(1'b0, mdl_acc[7:0], ST_OK);
        if (mdl_digits > 3'd3) st = ST_DEC_LONG;
      end
      PM_WORD: begin
        emit(1'b0, mdl_acc[15:8], ST_OK);
        emit(1'b0, mdl_acc[7:0], ST_OK);
      end
      PM_HEX: begin
        if (mdl_phase) begin
          emit(1'b0, {mdl_high, 4'h0}, ST_OK);
          st = ST_HEX_ODD;
        end
      end
      default: ;
    endcase
    mdl_mode = PM_TOP;
    clear_token();
    return st;
  endfunction

  // Handles a character at top level; returns 1 when the string ends here.
  function automatic bit top_char(input logic [7:0] c, input logic eos, output logic [1:0] st);
    st = ST_OK;
    case (c)
      CH_CR, CH_LF, CH_NUL: return 1'b1;
      CH_DOT:   mdl_mode = PM_DEC;
      CH_COLON: mdl_mode = PM_WORD;
      CH_HASH:  mdl_mode = PM_HEX;
      CH_AT:    mdl_mode = PM_ALPHA;
      CH_SKIP:  return 1'b0;
      default: begin
        st = ST_UNDEF;
        return 1'b1;
      end
    endcase
    clear_token();
    // A token opened by the last character is empty and dropped.
    if (eos) mdl_mode = PM_TOP;
    return 1'b0;
  endfunction

  // Works out the results of one accepted character and queues them.
  task automatic predict_char(input logic [7:0] c, input logic eos);
    logic [1:0] st;
    bit         fin;
    st  = ST_OK;
    fin = 1'b0;
    step_res.delete();
    // After the summary everything is ignored until the end-of-string flag.
    if (mdl_mode == PM_DONE) begin
      if (eos) restart_parser();
      return;
    end
    if (mdl_mode == PM_DEC && is_dec(c)) begin
      mdl_acc = mdl_acc * 16'd10 + 16'(nibble_of(c));
      if (mdl_digits < 3'd4) mdl_digits = mdl_digits + 3'd1;
    end else if (mdl_mode == PM_WORD && is_dec(c)) begin
      mdl_acc = mdl_acc * 16'd10 + 16'(nibble_of(c));
    end else if (mdl_mode == PM_HEX && is_hex(c)) begin
      if (mdl_phase) begin
        emit(1'b0, {mdl_high, nibble_of(c)}, ST_OK);
        mdl_phase = 1'b0;
      end else begin
        mdl_high  = nibble_of(c);
        mdl_phase = 1'b1;
      end
    end else if (mdl_mode == PM_ALPHA && is_alpha(c)) begin
      emit(1'b0, c, ST_OK);
    end else begin
      st = close_token();
      if (st != ST_OK) fin = 1'b1;
      else fin = top_char(c, eos, st);
    end
    if (!fin && eos) begin
      st  = close_token();
      fin = 1'b1;
    end
    if (fin) begin
      emit(1'b1, 8'h00, st);
      if (eos) restart_parser();
      else mdl_mode = PM_DONE;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_end = 1'b1;
    foreach (step_res[i]) byte_expect_q.push_back(step_res[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch at cycle %0d: %s got %0h, wanted %0h", cycle_count, what, got, exp_val);
    errors++;
  endtask

  // Offers one character, waits for its request to be taken, then predicts.
  task automatic send_char(input logic [7:0] c, input logic eos);
    bit ready_seen;
    while (!no_idle && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eos;
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    predict_char(c, eos);
  endtask

  task automatic send_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eos_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_char(input parse_mode_t k);
    int r;
    case (k)
      PM_DEC, PM_WORD: return CH_ZERO + 8'($urandom_range(0, 9));
      PM_HEX: begin
        r = $urandom_range(0, 21);
        if (r < 10) return CH_ZERO + 8'(r);
        if (r < 16) return 8'h61 + 8'(r - 10);
        return 8'h41 + 8'(r - 16);
      end
      PM_ALPHA: begin
        r = $urandom_range(0, 51);
        if (r < 26) return 8'h41 + 8'(r);
        return 8'h61 + 8'(r - 26);
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds a mostly well-formed string and sends it, flagged on its last character.
  task automatic send_random_string(output int sent);
    logic [7:0]  text[$];
    parse_mode_t k;
    int          len;
    int          ending;
    for (int t = 0; t < $urandom_range(1, 4); t++) begin
      case ($urandom_range(0, 4))
        0: begin
          k = PM_DEC;
          text.push_back(CH_DOT);
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
        end
        1: begin
          k = PM_WORD;
          text.push_back(CH_COLON);
          len = $urandom_range(0, 6);
        end
        2: begin
          k = PM_HEX;
          text.push_back(CH_HASH);
          len = $urandom_range(0, 7);
        end
        3: begin
          k = PM_ALPHA;
          text.push_back(CH_AT);
          len = $urandom_range(0, 5);
        end
        default: begin
          k = PM_TOP;
          text.push_back(CH_SKIP);
          len = 0;
        end
      endcase
      for (int i = 0; i < len; i++) text.push_back(pick_char(k));
      if ($urandom_range(0, 9) == 0) text.push_back(pick_char(PM_DONE));
    end
    ending = $urandom_range(0, 9);
    if (ending < 6) begin
      case ($urandom_range(0, 2))
        0:       text.push_back(CH_CR);
        1:       text.push_back(CH_LF);
        default: text.push_back(CH_NUL);
      endcase
      for (int i = 0; i < $urandom_range(0, 2); i++) text.push_back(pick_char(PM_DONE));
    end else if (ending == 9) begin
      text.push_back(pick_char(PM_DONE));
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    sent = text.size();
  endtask

  // Extremes of the token values and each special case of the grammar.
  task automatic test_directed();
    // Four decimal digits: byte wraps, then the long-token status.
    send_text(".1234:", 1'b1);
    // Largest word, then an odd hex run flushed by the end-of-string flag.
    send_text(":65535#F", 1'b1);
    // Letters, a skip, and a token opened by the last character.
    send_text("@Zz_.", 1'b1);
    // Digit zero at top level is undefined; the rest is ignored until the flag.
    send_char(CH_ZERO, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_NUL, 1'b1);
    // Empty decimal and word tokens, the word closed by a line feed.
    send_text(".:", 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_NUL, 1'b1);
  endtask

  task automatic test_random_strings(input int item_goal);
    int done;
    int sent;
    done = 0;
    while (done < item_goal) begin
      send_random_string(sent);
      done += sent;
    end
  endtask

  // The receiver holds off while word tokens keep the input busy.
  task automatic test_backpressure();
    -> hold_go;
    for (int i = 0; i < 12; i++) begin
      send_char(CH_COLON, 1'b0);
      send_char(pick_char(PM_DEC), 1'b0);
    end
    send_char(CH_LF, 1'b1);
  endtask

  // Arbitrary characters and flags, so that every input bit toggles.
  task automatic test_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  // Receiver readiness, with random idling unless held or in the busy stretch.
  always @(posedge clk) begin
    if (rst || holding) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  // Long hold-off of the receiver, counted here in cycles.
  initial begin
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // Each result taken at the next edge is compared with the oldest expectation.
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (byte_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected, tdata", m_tdata, 0);
      end else begin
        want = byte_expect_q.pop_front();
        if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
        if (m_tdata[7:0] !== want.data_byte)
          report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
        if (m_tdata[9:8] !== want.status) report_mismatch("status", m_tdata[9:8], want.status);
        if (m_tdata[25:10] !== want.byte_count)
          report_mismatch("byte_count", m_tdata[25:10], want.byte_count);
        if (m_tdata[OUT_DATA_W-1:26] !== '0)
          report_mismatch("padding", m_tdata[OUT_DATA_W-1:26], 0);
        if (m_tlast !== want.run_end) report_mismatch("run_end", m_tlast, want.run_end);
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_address_text_to_bytes_parser failed");
      $finish;
    end
  end

  initial begin
    restart_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    no_idle <= 1'b1;
    test_random_strings(60);
    no_idle <= 1'b0;
    test_backpressure();
    test_random_strings(170);
    test_noise(60);
    s_tvalid <= 1'b0;
    while (byte_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_address_text_to_bytes_parser passed");
    end else begin
      $display("tb_address_text_to_bytes_parser failed");
    end
    $finish;
  end

endmodule
